### src/ons_pkg.sv
`default_nettype none
package ons_pkg;

  // sizes of the generator
  localparam int MAX_OCTAVES      = 8;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COORD_BITS       = 12;

  // fixed field widths
  localparam int DIM_W   = 13;
  localparam int FREQ_W  = 16;
  localparam int OCT_W   = 4;
  localparam int CFG_W   = 16;
  localparam int PIX_W   = 8;
  localparam int PHASE_W = 16;
  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);

  // 6.28 / (2*pi) in Q0.16
  localparam logic [15:0] TURN_SCALE = 16'd65503;

  // phase datapath widths and depth
  localparam int M1_W       = COORD_BITS + FREQ_W;
  localparam int PROD_W     = M1_W + 16;
  localparam int NUM_W      = PROD_W - 8;
  localparam int DIV_STAGES = (NUM_W + 1) / 2;
  localparam int NUM_PAD    = 2 * DIV_STAGES;
  localparam int PH_STAGES  = DIV_STAGES + 2;

  // accumulator widths
  localparam int ACC_W     = 32 + MAX_OCTAVES;
  localparam int HALF      = (MAX_OCTAVES + 1) / 2;
  localparam int FRAC_BITS = 30 + MAX_OCTAVES - 1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_FREQ    = 2'd2,
    REG_OCTAVES = 2'd3
  } cfg_reg_t;

  typedef logic signed [15:0] sample_t;
  typedef sample_t sine_rom_t [SINE_TABLE_DEPTH];

  localparam longint Q30_ONE = 64'sd1073741824;

  // sin(pi/2 * t), t and result in Q30
  function automatic longint quarter_sine_q30(longint t);
    longint u;
    longint p;
    u = t * t / Q30_ONE;
    p = 64'sd172272;
    p = -64'sd5026995 + p * u / Q30_ONE;
    p = 64'sd85569306 + p * u / Q30_ONE;
    p = -64'sd693598668 + p * u / Q30_ONE;
    p = 64'sd1686629713 + p * u / Q30_ONE;
    return p * t / Q30_ONE;
  endfunction

  // one table entry: sin(2*pi*k/depth) in Q1.15
  function automatic sample_t sine_entry(int k);
    longint a;
    longint quad;
    longint rem;
    longint t;
    longint s;
    a    = longint'(k % SINE_TABLE_DEPTH) * 4;
    quad = a / SINE_TABLE_DEPTH;
    rem  = a % SINE_TABLE_DEPTH;
    t    = (rem <<< 30) / SINE_TABLE_DEPTH;
    if (quad % 2 == 1) begin
      t = Q30_ONE - t;
    end
    s = quarter_sine_q30(t);
    s = (s + 64'sd16384) / 64'sd32768;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    if (s < 0) begin
      s = 0;
    end
    if ((quad / 2) % 2 == 1) begin
      s = -s;
    end
    return sample_t'(s);
  endfunction

  function automatic sine_rom_t sine_table();
    sine_rom_t tbl;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

### src/ons_phase.sv
`default_nettype none
module ons_phase
  import ons_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [PH_STAGES-1:0]  en,
  input  wire logic [COORD_BITS-1:0] coord,
  input  wire logic [DIM_W-1:0]      dim,
  input  wire logic [FREQ_W-1:0]     freq,
  output      logic [PHASE_W-1:0]    phase
);

  logic [M1_W-1:0]   m1;
  logic [DIM_W-1:0]  d0;
  logic [PROD_W-1:0] prod;
  logic [NUM_PAD-1:0] num1;
  logic [DIM_W-1:0]  d1;

  // coord times frequency, divisor of zero taken as one
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1 <= M1_W'(coord) * M1_W'(freq);
      d0 <= (dim == '0) ? DIM_W'(1) : dim;
    end
  end

  // times turn scale, drop the 256 of the divisor
  assign prod = PROD_W'(m1) * PROD_W'(TURN_SCALE);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1 <= NUM_PAD'(prod[PROD_W-1:8]);
      d1   <= d0;
    end
  end

  // long division, two quotient bits per stage, only low quotient bits kept
  logic [NUM_PAD-1:0] dn [DIV_STAGES];
  logic [DIM_W-1:0]   dr [DIV_STAGES];
  logic [PHASE_W-1:0] dq [DIV_STAGES];
  logic [DIM_W-1:0]   dd [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [NUM_PAD-1:0] n_in;
    logic [DIM_W-1:0]   r_in;
    logic [PHASE_W-1:0] q_in;
    logic [DIM_W-1:0]   d_in;
    logic [NUM_PAD-1:0] n_next;
    logic [DIM_W-1:0]   r_next;
    logic [PHASE_W-1:0] q_next;

    if (j == 0) begin : g_first
      assign n_in = num1;
      assign r_in = '0;
      assign q_in = '0;
      assign d_in = d1;
    end else begin : g_rest
      assign n_in = dn[j-1];
      assign r_in = dr[j-1];
      assign q_in = dq[j-1];
      assign d_in = dd[j-1];
    end

    always_comb begin
      logic [DIM_W:0] r2;
      n_next = n_in;
      r_next = r_in;
      q_next = q_in;
      for (int b = 0; b < 2; b++) begin
        r2 = {r_next, n_next[NUM_PAD-1]};
        n_next = {n_next[NUM_PAD-2:0], 1'b0};
        if (r2 >= {1'b0, d_in}) begin
          r_next = DIM_W'(r2 - {1'b0, d_in});
          q_next = {q_next[PHASE_W-2:0], 1'b1};
        end else begin
          r_next = r2[DIM_W-1:0];
          q_next = {q_next[PHASE_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        dn[j] <= n_next;
        dr[j] <= r_next;
        dq[j] <= q_next;
        dd[j] <= d_in;
      end
    end
  end

  assign phase = dq[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/octave_sine_noise_pixel.sv
// Octave sine noise pixel generator.
// Input channel: pixel_x / pixel_y with in_valid / in_ready; one transfer per
// pixel. Output channel: intensity with out_valid / out_ready; one transfer
// per accepted pixel, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 width, 1 height, 2 frequency in 8.8, 3 octave count); write only
// while no pixel is in flight.
// Pipeline: 25 register stages (2 multiply stages, 18 stages of a radix-4 long
// divider per coordinate, table lookup, product, two adder tree stages and the
// scaling/output register).
// Throughput: one pixel per cycle unless the receiver stalls; the divider
// chain is fully pipelined.
// Reset clears all stage valid bits and loads the register defaults
// (256, 256, 4.0, 4 octaves).
// When the receiver stalls, stages hold their data and bubbles are squeezed
// out, so input keeps being taken until every stage is full.
`default_nettype none
module octave_sine_noise_pixel
  import ons_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [COORD_BITS-1:0] pixel_x,
  input  wire logic [COORD_BITS-1:0] pixel_y,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [PIX_W-1:0]      intensity
);

  localparam int ST_ROM = PH_STAGES;
  localparam int ST_MUL = PH_STAGES + 1;
  localparam int ST_A1  = PH_STAGES + 2;
  localparam int ST_A2  = PH_STAGES + 3;
  localparam int ST_OUT = PH_STAGES + 4;
  localparam int NS     = PH_STAGES + 5;

  localparam sine_rom_t SINE_ROM = sine_table();

  // configuration registers
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [FREQ_W-1:0] frequency_q8_8;
  logic [OCT_W-1:0]  octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(256);
      image_height   <= DIM_W'(256);
      frequency_q8_8 <= FREQ_W'(1024);
      octave_count   <= OCT_W'(4);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:   image_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:  image_height   <= cfg_data[DIM_W-1:0];
        REG_FREQ:    frequency_q8_8 <= cfg_data[FREQ_W-1:0];
        REG_OCTAVES: octave_count   <= cfg_data[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage enables
  logic [NS-1:0] pipe_valid;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !pipe_valid[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          pipe_valid[k] <= (k == 0) ? in_valid : pipe_valid[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // phases of both coordinates
  logic [PHASE_W-1:0] px;
  logic [PHASE_W-1:0] py;

  ons_phase u_phase_x (
    .clk   (clk),
    .en    (en[PH_STAGES-1:0]),
    .coord (pixel_x),
    .dim   (image_width),
    .freq  (frequency_q8_8),
    .phase (px)
  );

  ons_phase u_phase_y (
    .clk   (clk),
    .en    (en[PH_STAGES-1:0]),
    .coord (pixel_y),
    .dim   (image_height),
    .freq  (frequency_q8_8),
    .phase (py)
  );

  // table lookups per octave
  sample_t sin_q [MAX_OCTAVES];
  sample_t cos_q [MAX_OCTAVES];

  always_ff @(posedge clk) begin
    logic [PHASE_W-1:0] sp;
    logic [PHASE_W-1:0] cp;
    if (en[ST_ROM]) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        sp = px << i;
        cp = (py << i) + PHASE_W'(16'h4000);
        sin_q[i] <= SINE_ROM[sp[PHASE_W-1 -: ADDR_W]];
        cos_q[i] <= SINE_ROM[cp[PHASE_W-1 -: ADDR_W]];
      end
    end
  end

  // sin times cos, Q2.30
  logic signed [31:0] prod_q [MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        prod_q[i] <= 32'(sin_q[i]) * 32'(cos_q[i]);
      end
    end
  end

  // weight by amplitude, mask unused octaves, first adder level
  logic signed [ACC_W-1:0] pair_sum [HALF];

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] term [MAX_OCTAVES+1];
    if (en[ST_A1]) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        if ({1'b0, octave_count} > 5'(i)) begin
          term[i] = ACC_W'(prod_q[i]) <<< (MAX_OCTAVES - 1 - i);
        end else begin
          term[i] = '0;
        end
      end
      term[MAX_OCTAVES] = '0;
      for (int j = 0; j < HALF; j++) begin
        pair_sum[j] <= term[2*j] + term[2*j+1];
      end
    end
  end

  // final adder level
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] s;
    if (en[ST_A2]) begin
      s = '0;
      for (int j = 0; j < HALF; j++) begin
        s = s + pair_sum[j];
      end
      acc <= s;
    end
  end

  // offset, clamp and scale by 255 to the output register
  localparam logic signed [ACC_W:0] FULL     = (ACC_W+1)'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_W:0] FULL_TWO = (ACC_W+1)'(1) <<< (FRAC_BITS + 1);

  logic signed [ACC_W:0] v;
  logic [ACC_W-1:0]      vc;
  logic [ACC_W+7:0]      scaled;

  always_comb begin
    v = {acc[ACC_W-1], acc} + FULL;
    if (v < 0) begin
      vc = '0;
    end else if (v > FULL_TWO) begin
      vc = FULL_TWO[ACC_W-1:0];
    end else begin
      vc = v[ACC_W-1:0];
    end
    scaled = {vc, 8'b0} - (ACC_W+8)'(vc);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      intensity <= scaled[FRAC_BITS+1 +: PIX_W];
    end
  end

  assign out_valid = pipe_valid[NS-1];

  // checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pipe_valid[0])
    else $error("input stalled with an empty first stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pipe_valid[0])
    else $error("accepted pixel not captured in first stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(intensity))
    else $error("stalled result dropped or changed");

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb
  import ons_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] pixel_x = '0;
  logic [COORD_BITS-1:0] pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] intensity;

  octave_sine_noise_pixel dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the configuration
  logic [12:0] img_w = 13'd256;
  logic [12:0] img_h = 13'd256;
  logic [15:0] freq = 16'd1024;
  logic [3:0] octaves = 4'd4;

  logic signed [15:0] wave [SINE_TABLE_DEPTH];
  logic [7:0] grey_q [$];
  int typed_grey = -1;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;
  int stuck = 0;

  // polynomial sine over a quarter turn, Q30 in and out
  function automatic longint quarter_wave(longint t);
    longint u;
    longint p;
    u = t * t / 64'sd1073741824;
    p = 64'sd172272;
    p = -64'sd5026995 + p * u / 64'sd1073741824;
    p = 64'sd85569306 + p * u / 64'sd1073741824;
    p = -64'sd693598668 + p * u / 64'sd1073741824;
    p = 64'sd1686629713 + p * u / 64'sd1073741824;
    return p * t / 64'sd1073741824;
  endfunction

  // fill the sine table in Q1.15
  task automatic build_wave();
    longint a;
    longint q;
    longint t;
    longint s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      a = longint'(k) * 4;
      q = a / SINE_TABLE_DEPTH;
      t = ((a % SINE_TABLE_DEPTH) <<< 30) / SINE_TABLE_DEPTH;
      if (q[0]) t = 64'sd1073741824 - t;
      s = (quarter_wave(t) + 64'sd16384) / 64'sd32768;
      if (s > 32767) s = 32767;
      if (s < 0) s = 0;
      wave[k] = 16'(q[1] ? -s : s);
    end
  endtask

  function automatic logic [15:0] turn_phase(logic [11:0] c, logic [12:0] dim);
    longint unsigned d;
    longint unsigned num;
    d = (dim == 0) ? 1 : dim;
    num = longint'(c) * longint'(freq) * 65503;
    return 16'(num / (d * 256));
  endfunction

  // expected grey level for one pixel
  function automatic logic [7:0] grey_level(logic [11:0] x, logic [11:0] y);
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] sp;
    logic [15:0] cp;
    int n;
    longint acc;
    longint v;
    longint full;
    px = turn_phase(x, img_w);
    py = turn_phase(y, img_h);
    n = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
    acc = 0;
    full = 64'sd1 <<< (30 + MAX_OCTAVES - 1);
    for (int i = 0; i < n; i++) begin
      sp = px << i;
      cp = (py << i) + 16'h4000;
      acc += (longint'(wave[sp[15:6]]) * longint'(wave[cp[15:6]]))
             <<< (MAX_OCTAVES - 1 - i);
    end
    v = acc + full;
    if (v < 0) v = 0;
    if (v > 2 * full) v = 2 * full;
    return 8'((v * 255) / (2 * full));
  endfunction

  // transfer monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        grey_q.insert(grey_q.size(),
                      typed_grey >= 0 ? 8'(typed_grey) : grey_level(pixel_x, pixel_y));
      if (out_valid && out_ready) begin
        if (grey_q.size() == 0) begin
          $error("intensity: unexpected result %0d", intensity);
          errors++;
        end else begin
          logic [7:0] want;
          want = grey_q.pop_front();
          if (intensity !== want) begin
            $error("intensity: expected %0d actual %0d", want, intensity);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 3000) begin
      $display("[octave_sine_noise_pixel] ERROR");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int n;
    bit held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // one pixel, called at a falling edge
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, int typed);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_x = x;
    pixel_y = y;
    typed_grey = typed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_WIDTH: img_w = val[12:0];
      REG_HEIGHT: img_h = val[12:0];
      REG_FREQ: freq = val;
      REG_OCTAVES: octaves = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait until every result has come back, ending at a falling edge
  task automatic drain();
    in_valid = 1'b0;
    while (grey_q.size() != 0) @(negedge clk);
  endtask

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    int grey;
  } pixel_row_t;

  typedef struct {
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] f;
    logic [15:0] o;
  } setting_t;

  pixel_row_t directed [12] = '{
    '{12'd0, 12'd0, 127}, '{12'd4095, 12'd4095, -1}, '{12'd4095, 12'd0, -1},
    '{12'd0, 12'd4095, -1}, '{12'd1, 12'd1, -1}, '{12'd64, 12'd0, -1},
    '{12'd2048, 12'd1024, -1}, '{12'd2730, 12'd1365, -1}, '{12'd1365, 12'd2730, -1},
    '{12'd32, 12'd96, -1}, '{12'd100, 12'd200, -1}, '{12'd4000, 12'd17, -1}
  };

  setting_t settings [9] = '{
    '{16'd1, 16'd1, 16'd65535, 16'd8},
    '{16'd4096, 16'd4096, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd256, 16'd15},
    '{16'd8191, 16'd8191, 16'd1, 16'd1},
    '{16'd640, 16'd480, 16'd1024, 16'd4},
    '{16'd4095, 16'd1, 16'd32768, 16'd7},
    '{16'd256, 16'd256, 16'd1024, 16'd4},
    '{16'd37, 16'd3000, 16'd4660, 16'd2},
    '{16'd512, 16'd128, 16'd43690, 16'd8}
  };

  // main sequence
  initial begin
    build_wave();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed rows at reset defaults
    foreach (directed[i]) send_pixel(directed[i].x, directed[i].y, directed[i].grey);

    // configuration phases with random pixels
    foreach (settings[p]) begin
      drain();
      write_reg(REG_WIDTH, settings[p].w);
      write_reg(REG_HEIGHT, settings[p].h);
      write_reg(REG_FREQ, settings[p].f);
      write_reg(REG_OCTAVES, settings[p].o);
      if (p == 1) send_pixel(12'd4095, 12'd4095, 127);
      if (p == 2) hold_req = 1'b1;
      if (p == 8) quiet = 1'b1;
      repeat (170) send_pixel(12'($urandom), 12'($urandom), -1);
    end

    drain();
    repeat (60) @(negedge clk);
    if (errors == 0 && grey_q.size() == 0) begin
      $display("[octave_sine_noise_pixel] OK");
    end else begin
      $display("[octave_sine_noise_pixel] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/ons_pkg.sv
src/ons_phase.sv
src/octave_sine_noise_pixel.sv
bench/tb.sv
